// ===== rtl/core/tdsac_pkg.sv =====
// ----------------------------------------------------------------------------
// tdsac_pkg
// Types and constants shared by the TDS average-and-convert block.
// ----------------------------------------------------------------------------
package tdsac_pkg;

  localparam int unsigned SumW  = 18;
  localparam int unsigned NumW  = 47;
  localparam int unsigned DenW  = 30;

  localparam logic [25:0] CoefCube   = 26'd8743895;
  localparam logic [25:0] CoefSquare = 26'd16768041;
  localparam logic [25:0] CoefLinear = 26'd56189911;
  localparam logic [17:0] VMax       = 18'h3FFFF;
  localparam logic [23:0] PpmMax     = 24'hFFFFFF;
  localparam logic signed [15:0] TMin = -16'sd5120;
  localparam logic signed [15:0] TMax = 16'sd25600;
  localparam logic [14:0] TOffset    = 15'd6400;

  localparam logic [7:0] RegFullScale = 8'd0;
  localparam logic [7:0] RegVref      = 8'd1;
  localparam logic [7:0] RegCellConst = 8'd2;
  localparam logic [7:0] RegTdsFactor = 8'd3;

  typedef struct packed {
    logic [11:0]        adc_sample;
    logic signed [15:0] temperature_q8;
  } in_item_t;

  typedef struct packed {
    logic [23:0] tds_ppm_q8;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [12:0] adc_full_scale;
    logic [12:0] vref_millivolts;
    logic [17:0] cell_constant_q16;
    logic [16:0] tds_factor_q16;
  } cfg_t;

  typedef struct packed {
    logic [SumW-1:0]    sum;
    logic signed [15:0] temp;
  } window_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            busy;
    logic [NumW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/tdsac_front.sv =====
// ----------------------------------------------------------------------------
// tdsac_front
// Window accumulator: sums samples and hands finished windows to the queue.
// ----------------------------------------------------------------------------
module tdsac_front import tdsac_pkg::*; #(
  parameter int unsigned SAMPLES = 30
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     q_full_i,
  output logic     q_push_o,
  output window_t  q_data_o
);

  localparam int unsigned CntW = $clog2(SAMPLES + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(SAMPLES - 1);

  logic [SumW-1:0] sum_q, sum_d, sum_new;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            take, last;

  assign in_stall_o = q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign sum_new    = sum_q + SumW'(in_item_i.adc_sample);
  assign last       = (cnt_q == LastCnt);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (take) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  assign q_push_o      = take && last;
  assign q_data_o.sum  = sum_new;
  assign q_data_o.temp = in_item_i.temperature_q8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/tdsac_queue.sv =====
// ----------------------------------------------------------------------------
// tdsac_queue
// Two-entry queue of finished windows between front and back.
// ----------------------------------------------------------------------------
module tdsac_queue import tdsac_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  window_t data_i,
  input  logic    pop_i,
  output window_t data_o,
  output logic    full_o,
  output logic    empty_o
);

  window_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

endmodule

// ===== rtl/core/tdsac_div.sv =====
// ----------------------------------------------------------------------------
// tdsac_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdsac_div import tdsac_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(NumW);

  logic            busy_q, done_q;
  logic [StepW-1:0] step_q;
  logic [NumW-1:0] n_q;
  logic [DenW-1:0] r_q, d_q;
  logic [DenW:0]   rs;
  logic            ge;

  assign rs = {r_q, n_q[NumW-1]};
  assign ge = rs >= {1'b0, d_q};

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      n_q <= req_i.num;
      d_q <= req_i.den;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= ge ? DenW'(rs - {1'b0, d_q}) : DenW'(rs);
      n_q <= {n_q[NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == StepW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + StepW'(1);
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = n_q;

endmodule

// ===== rtl/core/tdsac_back.sv =====
// ----------------------------------------------------------------------------
// tdsac_back
// Window conversion: voltage, cubic EC, cell constant, temperature
// compensation and TDS factor, sequenced over a shared multiplier path and
// divider.
// ----------------------------------------------------------------------------
module tdsac_back import tdsac_pkg::*; #(
  parameter int unsigned SAMPLES = 30
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  window_t   q_data_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  localparam logic [16:0] ScaleDen = 17'(SAMPLES * 1000);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StVDiv  = 4'd1;
  localparam logic [3:0] StVWait = 4'd2;
  localparam logic [3:0] StSq    = 4'd3;
  localparam logic [3:0] StCu    = 4'd4;
  localparam logic [3:0] StM3    = 4'd5;
  localparam logic [3:0] StM2    = 4'd6;
  localparam logic [3:0] StM1    = 4'd7;
  localparam logic [3:0] StSum   = 4'd8;
  localparam logic [3:0] StEc    = 4'd9;
  localparam logic [3:0] StEck   = 4'd10;
  localparam logic [3:0] StPtf   = 4'd11;
  localparam logic [3:0] StPDiv  = 4'd12;
  localparam logic [3:0] StPWait = 4'd13;
  localparam logic [3:0] StOut   = 4'd14;

  logic [3:0]         st_q;
  logic [14:0]        tden_q;
  logic [30:0]        sv_q;
  logic [17:0]        v_q;
  logic [19:0]        v2_q;
  logic [21:0]        v3_q;
  logic [47:0]        prod_q;
  logic signed [49:0] acc_q;
  logic [29:0]        ec_q;
  logic [31:0]        eck_q;
  logic [48:0]        p_q;
  logic [23:0]        ppm_q;
  logic               sat_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [12:0]        fs;
  logic signed [15:0] tc;
  logic [53:0]        p25;
  div_req_t           dreq;
  div_rsp_t           drsp;

  assign fs  = (cfg_i.adc_full_scale == '0) ? 13'd1 : cfg_i.adc_full_scale;
  assign tc  = (q_data_i.temp < TMin) ? TMin : (q_data_i.temp > TMax) ? TMax : q_data_i.temp;
  assign p25 = {1'b0, p_q, 4'b0} + {2'b0, p_q, 3'b0} + {5'b0, p_q};

  always_comb begin
    dreq = '0;
    unique case (st_q)
      StVDiv: begin
        dreq.start = 1'b1;
        dreq.num   = {sv_q, 16'b0};
        dreq.den   = fs * ScaleDen;
      end
      StPDiv: begin
        dreq.start = 1'b1;
        dreq.num   = NumW'(p25 >> 15);
        dreq.den   = {15'b0, tden_q};
      end
      default: ;
    endcase
  end

  tdsac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign q_pop_o = (st_q == StIdle) && !q_empty_i;

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        sv_q   <= 31'(q_data_i.sum * cfg_i.vref_millivolts);
        tden_q <= 15'(tc + 16'sd6400);
      end
      StVDiv: ;
      StVWait: begin
        if (drsp.done) begin
          v_q <= (drsp.quot > NumW'(VMax)) ? VMax : drsp.quot[17:0];
        end
      end
      StSq:  v2_q   <= 20'((36'(v_q) * 36'(v_q)) >> 16);
      StCu:  v3_q   <= 22'((38'(v2_q) * 38'(v_q)) >> 16);
      StM3:  prod_q <= 48'(CoefCube * v3_q);
      StM2: begin
        acc_q  <= $signed({2'b0, prod_q});
        prod_q <= 48'(CoefSquare * v2_q);
      end
      StM1: begin
        acc_q  <= acc_q - $signed({2'b0, prod_q});
        prod_q <= 48'(CoefLinear * v_q);
      end
      StSum: acc_q <= acc_q + $signed({2'b0, prod_q});
      StEc:  ec_q  <= acc_q[49] ? '0 : acc_q[45:16];
      StEck: eck_q <= 32'((48'(ec_q) * 48'(cfg_i.cell_constant_q16)) >> 16);
      StPtf: p_q   <= 49'(eck_q) * 49'(cfg_i.tds_factor_q16);
      StPDiv: ;
      StPWait: begin
        if (drsp.done) begin
          sat_q <= drsp.quot > NumW'(PpmMax);
          ppm_q <= (drsp.quot > NumW'(PpmMax)) ? PpmMax : drsp.quot[23:0];
        end
      end
      StOut: ;
      default: ;
    endcase
    if (st_q == StOut && (!out_valid_q || !out_stall_i)) begin
      out_q.tds_ppm_q8 <= ppm_q;
      out_q.saturated  <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == StOut && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        StIdle:  if (!q_empty_i) st_q <= StVDiv;
        StVDiv:  st_q <= StVWait;
        StVWait: if (drsp.done) st_q <= StSq;
        StSq:    st_q <= StCu;
        StCu:    st_q <= StM3;
        StM3:    st_q <= StM2;
        StM2:    st_q <= StM1;
        StM1:    st_q <= StSum;
        StSum:   st_q <= StEc;
        StEc:    st_q <= StEck;
        StEck:   st_q <= StPtf;
        StPtf:   st_q <= StPDiv;
        StPDiv:  st_q <= StPWait;
        StPWait: if (drsp.done) st_q <= StOut;
        StOut: begin
          if (!out_valid_q || !out_stall_i) begin
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/tds_sensor_average_and_convert.sv =====
// ----------------------------------------------------------------------------
// tds_sensor_average_and_convert
// Averages a window of probe samples and converts it to TDS ppm (Q16.8).
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item_t
//   out      output     out_valid / stall    out_item_t
//   cfg      input      cfg_valid / ready    cfg_index, cfg_data
//
// A sample is taken whenever in_valid is high and the window queue has room.
// Window end: the finished window passes through the queue, then the two
// 47-step divisions in the shared divider and the multiply sequence, before
// the result is registered.
// Reset clears the window sum, count, queue and sequencer; config resets.
// Out stall holds the result register; two finished windows may queue.
// ----------------------------------------------------------------------------
module tds_sensor_average_and_convert import tdsac_pkg::*; #(
  parameter int unsigned SAMPLES = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_item_t    in_item_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output out_item_t   out_item_o,
  input  logic        out_stall_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t    cfg_q;
  window_t q_in, q_out;
  logic    q_push, q_pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_full_scale    <= 13'd4095;
      cfg_q.vref_millivolts   <= 13'd3300;
      cfg_q.cell_constant_q16 <= 18'd65536;
      cfg_q.tds_factor_q16    <= 17'd32768;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegFullScale: cfg_q.adc_full_scale    <= cfg_data_i[12:0];
        RegVref:      cfg_q.vref_millivolts   <= cfg_data_i[12:0];
        RegCellConst: cfg_q.cell_constant_q16 <= cfg_data_i[17:0];
        RegTdsFactor: cfg_q.tds_factor_q16    <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  tdsac_front #(.SAMPLES(SAMPLES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  tdsac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tdsac_back #(.SAMPLES(SAMPLES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_data_i    (q_out),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule
